FILE: rtl/core/cpio_pkg.sv
// Shared constants and types for the cpio newc stream parser.
package cpio_pkg;

    // Field widths of the byte and result channels.
    localparam int BYTE_W    = 8;
    localparam int SECTION_W = 3;
    localparam int ENTRY_W   = 7;
    localparam int SIZE_W    = 32;

    // Default number of archive entries that the entry counter distinguishes.
    localparam int MAX_ENTRIES = 128;

    // Layout of the newc header.
    localparam int HEADER_LEN       = 110;
    localparam int FILESIZE_AT      = 54;
    localparam int NAMESIZE_AT      = 94;
    localparam int SIZE_DIGITS      = 8;
    localparam int TRAILER_LEN      = 10;
    localparam int TRAILER_NAMESIZE = 11;

    // Part of an entry that a byte belongs to.
    typedef enum logic [SECTION_W-1:0] {
        SEC_HEADER,
        SEC_NAME,
        SEC_NAME_PAD,
        SEC_DATA,
        SEC_DATA_PAD,
        SEC_DONE
    } t_section;

endpackage

FILE: rtl/core/cpio_stream_if.sv
// Valid/ready channel interfaces for archive bytes and parse results.
interface cpio_byte_if;
    logic                         valid;
    logic                         ready;
    logic [cpio_pkg::BYTE_W-1:0]  data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

interface cpio_result_if;
    logic                           valid;
    logic                           ready;
    logic [cpio_pkg::BYTE_W-1:0]    byte_out;
    logic [cpio_pkg::SECTION_W-1:0] section;
    logic [cpio_pkg::ENTRY_W-1:0]   entry_number;
    logic [cpio_pkg::SIZE_W-1:0]    section_offset;
    logic [cpio_pkg::SIZE_W-1:0]    name_length;
    logic [cpio_pkg::SIZE_W-1:0]    data_length;
    logic                           trailer_seen;
    logic                           hex_error;

    modport source (
        output valid, output byte_out, output section, output entry_number,
        output section_offset, output name_length, output data_length,
        output trailer_seen, output hex_error, input ready
    );
    modport sink (
        input valid, input byte_out, input section, input entry_number,
        input section_offset, input name_length, input data_length,
        input trailer_seen, input hex_error, output ready
    );
endinterface

FILE: rtl/core/cpio_newc_stream_parser.sv
// cpio newc stream parser: classifies each archive byte and decodes header sizes.
// Each accepted byte's result is registered in the output or skid register.
// Throughput: one byte per cycle while the skid register is empty.
// A skid register takes one more byte while a result waits; then the input stalls.
// Reset (i_rst_n low, synchronous) returns to the start of a header, entry zero,
// and empties both result registers.
module cpio_newc_stream_parser #(
    parameter int MAX_ENTRIES = cpio_pkg::MAX_ENTRIES
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    cpio_byte_if.sink             i_in,
    cpio_result_if.source         o_res
);

    localparam int ENTRY_MAX      = (1 << cpio_pkg::ENTRY_W) - 1;
    localparam int ENTRY_LIMIT    = (MAX_ENTRIES - 1 > ENTRY_MAX)
                                    ? ENTRY_MAX : MAX_ENTRIES - 1;
    localparam int NAME_IDX_W     = $clog2(cpio_pkg::TRAILER_LEN);
    localparam int DIGIT_W        = 4;

    localparam logic [cpio_pkg::BYTE_W-1:0] TRAILER_TEXT [cpio_pkg::TRAILER_LEN] = '{
        "T", "R", "A", "I", "L", "E", "R", "!", "!", "!"
    };

    typedef struct packed {
        logic [cpio_pkg::BYTE_W-1:0]  byte_out;
        cpio_pkg::t_section           section;
        logic [cpio_pkg::ENTRY_W-1:0] entry_number;
        logic [cpio_pkg::SIZE_W-1:0]  section_offset;
        logic [cpio_pkg::SIZE_W-1:0]  name_length;
        logic [cpio_pkg::SIZE_W-1:0]  data_length;
        logic                         trailer_seen;
        logic                         hex_error;
    } t_result;

    typedef struct packed {
        logic               bad;
        logic [DIGIT_W-1:0] value;
    } t_digit;

    // Decode one ASCII hex digit; anything else reads as zero and is flagged.
    function automatic t_digit hex_digit(input logic [cpio_pkg::BYTE_W-1:0] c);
        t_digit d;
        d.bad   = 1'b0;
        d.value = '0;
        priority if (c >= "0" && c <= "9") begin
            d.value = c[DIGIT_W-1:0];
        end else if ((c >= "A" && c <= "F") || (c >= "a" && c <= "f")) begin
            d.value = c[DIGIT_W-1:0] + DIGIT_W'(9);
        end else begin
            d.bad = 1'b1;
        end
        return d;
    endfunction

    // Parse state.
    cpio_pkg::t_section           r_phase,   n_phase;
    logic [cpio_pkg::SIZE_W-1:0]  r_count,   n_count;
    logic [cpio_pkg::SIZE_W-1:0]  r_nsize,   n_nsize;
    logic [cpio_pkg::SIZE_W-1:0]  r_fsize,   n_fsize;
    logic [cpio_pkg::ENTRY_W-1:0] r_entry,   n_entry;
    logic                         r_trailer, n_trailer;
    logic                         r_err,     n_err;
    logic [1:0]                   r_align,   n_align;

    // Result registers.
    t_result r_out, r_skid, n_res;
    logic    r_out_valid, r_skid_valid;

    logic    accept;
    logic    out_free;
    t_digit  digit;
    logic    in_fsize, in_nsize;
    logic    name_cmp;
    logic [cpio_pkg::BYTE_W-1:0] b;

    assign b        = i_in.data_byte;
    assign accept   = i_in.valid && !r_skid_valid;
    assign out_free = !r_out_valid || o_res.ready;
    assign digit    = hex_digit(b);
    assign in_fsize = (r_count >= cpio_pkg::SIZE_W'(cpio_pkg::FILESIZE_AT)) &&
                      (r_count <  cpio_pkg::SIZE_W'(cpio_pkg::FILESIZE_AT +
                                                    cpio_pkg::SIZE_DIGITS));
    assign in_nsize = (r_count >= cpio_pkg::SIZE_W'(cpio_pkg::NAMESIZE_AT)) &&
                      (r_count <  cpio_pkg::SIZE_W'(cpio_pkg::NAMESIZE_AT +
                                                    cpio_pkg::SIZE_DIGITS));
    assign name_cmp = (r_phase == cpio_pkg::SEC_NAME) &&
                      (r_count < cpio_pkg::SIZE_W'(cpio_pkg::TRAILER_LEN));

    // Result of the current byte and the parse state it leaves behind.
    always_comb begin
        n_phase   = r_phase;
        n_count   = r_count + 1'b1;
        n_nsize   = r_nsize;
        n_fsize   = r_fsize;
        n_entry   = r_entry;
        n_trailer = r_trailer;
        n_err     = r_err;
        n_align   = r_align;

        // Header bytes: restart the entry and shift in size digits.
        if (r_phase == cpio_pkg::SEC_HEADER) begin
            if (r_count == '0) begin
                n_nsize   = '0;
                n_fsize   = '0;
                n_err     = 1'b0;
                n_trailer = 1'b1;
            end
            if (in_fsize) begin
                n_fsize = {n_fsize[cpio_pkg::SIZE_W-DIGIT_W-1:0], digit.value};
                n_err   = n_err | digit.bad;
            end
            if (in_nsize) begin
                n_nsize = {n_nsize[cpio_pkg::SIZE_W-DIGIT_W-1:0], digit.value};
                n_err   = n_err | digit.bad;
            end
        end else if (name_cmp && b != TRAILER_TEXT[r_count[NAME_IDX_W-1:0]]) begin
            n_trailer = 1'b0;
        end

        n_res.byte_out       = b;
        n_res.section        = r_phase;
        n_res.entry_number   = r_entry;
        n_res.section_offset = r_count;
        n_res.name_length    = n_nsize;
        n_res.data_length    = n_fsize;
        n_res.trailer_seen   = (r_phase == cpio_pkg::SEC_HEADER) ? 1'b0 : n_trailer;
        n_res.hex_error      = n_err;

        if (r_phase != cpio_pkg::SEC_DONE) begin
            n_align = r_align + 1'b1;
            // Last header byte opens the name section.
            if (r_phase == cpio_pkg::SEC_HEADER &&
                r_count == cpio_pkg::SIZE_W'(cpio_pkg::HEADER_LEN - 1)) begin
                n_trailer = (n_nsize == cpio_pkg::SIZE_W'(cpio_pkg::TRAILER_NAMESIZE));
                n_phase   = cpio_pkg::SEC_NAME;
                n_count   = '0;
            end
            // Step past finished or empty sections.
            if (n_phase == cpio_pkg::SEC_NAME && n_count == n_nsize) begin
                n_phase = cpio_pkg::SEC_NAME_PAD;
                n_count = '0;
            end
            if (n_phase == cpio_pkg::SEC_NAME_PAD && n_align == 2'd0) begin
                n_phase = cpio_pkg::SEC_DATA;
                n_count = '0;
            end
            if (n_phase == cpio_pkg::SEC_DATA && n_count == n_fsize) begin
                n_phase = cpio_pkg::SEC_DATA_PAD;
                n_count = '0;
            end
            if (n_phase == cpio_pkg::SEC_DATA_PAD && n_align == 2'd0) begin
                n_count = '0;
                if (n_trailer) begin
                    n_phase = cpio_pkg::SEC_DONE;
                end else begin
                    n_phase = cpio_pkg::SEC_HEADER;
                    if (r_entry < cpio_pkg::ENTRY_W'(ENTRY_LIMIT)) begin
                        n_entry = r_entry + 1'b1;
                    end
                end
            end
        end
    end

    // Parse state and result register occupancy.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= cpio_pkg::SEC_HEADER;
            r_count      <= '0;
            r_nsize      <= '0;
            r_fsize      <= '0;
            r_entry      <= '0;
            r_trailer    <= 1'b1;
            r_err        <= 1'b0;
            r_align      <= '0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_phase   <= n_phase;
                r_count   <= n_count;
                r_nsize   <= n_nsize;
                r_fsize   <= n_fsize;
                r_entry   <= n_entry;
                r_trailer <= n_trailer;
                r_err     <= n_err;
                r_align   <= n_align;
            end
            if (out_free) begin
                if (r_skid_valid) begin
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out_valid <= accept;
                end
            end else if (accept) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    // Result payload: a stalled output parks the new result in the skid register.
    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (accept) begin
                r_out <= n_res;
            end
        end else if (accept) begin
            r_skid <= n_res;
        end
    end

    assign i_in.ready           = !r_skid_valid;
    assign o_res.valid          = r_out_valid;
    assign o_res.byte_out       = r_out.byte_out;
    assign o_res.section        = r_out.section;
    assign o_res.entry_number   = r_out.entry_number;
    assign o_res.section_offset = r_out.section_offset;
    assign o_res.name_length    = r_out.name_length;
    assign o_res.data_length    = r_out.data_length;
    assign o_res.trailer_seen   = r_out.trailer_seen;
    assign o_res.hex_error      = r_out.hex_error;

endmodule
